// ===== rtl/pler_pkg.sv =====
// pler_pkg: shared types and constants for the polyline edge rasterizer.
// Beat structs for the vertex and cell channels, register indexes, sequencer
// states and the control bundle of the stepping unit. No dependencies.
`timescale 1ns / 1ps

package pler_pkg;

    localparam int VERTEX_W  = 8;
    localparam int CELL_W    = 6;
    localparam int GRID_W    = 7;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_GRID_WIDTH  = 2'd0;
    localparam cfg_idx_t REG_GRID_HEIGHT = 2'd1;

    localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

    typedef struct packed {
        logic signed [VERTEX_W-1:0] vertex_x;
        logic signed [VERTEX_W-1:0] vertex_y;
    } vertex_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_x;
        logic [CELL_W-1:0] cell_y;
        logic [CELL_W-1:0] box_min_x;
        logic [CELL_W-1:0] box_min_y;
        logic [CELL_W-1:0] box_max_x;
        logic [CELL_W-1:0] box_max_y;
        logic              box_valid;
        logic              out_of_range;
        logic              last_of_run;
    } cell_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_VERTEX,
        ST_GAP
    } seq_state_t;

    // stepping unit control: load a new segment, or advance one cell
    typedef struct packed {
        logic load;
        logic advance;
    } step_ctrl_t;

endpackage

// ===== rtl/polyline_edge_rasterizer.sv =====
// polyline_edge_rasterizer: top level, vertex intake, sequencer and cell output.
// Depends on pler_pkg and pler_stepper.
`timescale 1ns / 1ps

// Usage
//   Vertex channel (in_valid / in_stall / in_data): one beat per polyline vertex.
//   Cell channel (out_valid / out_stall / out_data): one beat per marked cell;
//   the vertex itself comes first, then the gap cells between it and the
//   previous vertex in ascending order, last_of_run set on the final beat. A vertex
//   outside the grid gives a single flagged beat and leaves polyline and box alone.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): grid width
//   and height, written between vertices; cfg_ready is always high.
// Sequence
//   In-range vertex: accept, a setup state, then the vertex beat and its N gap
//   cells (N up to 62), one beat per cycle while the output is not stalled.
//   Out-of-range vertex: accept, then its single beat, with no setup state.
//   The stepping unit produces one gap cell per cycle, held while stalled.
//   in_stall stays high from accept until the last beat enters the output
//   register; the next vertex may be accepted while that beat is still held.
// Reset clears the polyline and box, sets grid size to 64 x 64 and empties
// the output register. A stalled receiver holds the sequencer in its vertex and gap states.

module polyline_edge_rasterizer #(
    parameter int MAX_DIM = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  pler_pkg::vertex_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output pler_pkg::cell_t    out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  pler_pkg::cfg_idx_t cfg_index,
    input  logic [pler_pkg::GRID_W-1:0] cfg_data
);

    import pler_pkg::*;

    localparam int COORD_W = (MAX_DIM >= 128) ? 7 : $clog2(MAX_DIM);
    localparam logic [10:0] DIM_LIMIT = 11'(MAX_DIM);

    typedef logic [COORD_W-1:0] coord_t;

    seq_state_t state_reg, state_next;

    logic [GRID_W-1:0] gw_reg;
    logic [GRID_W-1:0] gh_reg;
    logic   have_point_reg;
    coord_t prev_x_reg, prev_y_reg;
    coord_t min_x_reg, min_y_reg, max_x_reg, max_y_reg;
    coord_t cur_x_reg, cur_y_reg;
    coord_t old_x_reg, old_y_reg;
    logic   had_reg;
    logic   oor_reg;
    logic   step_y_reg;
    coord_t gap_cnt_reg;
    logic   out_valid_reg;
    cell_t  out_data_reg;

    logic   accept;
    logic   in_range;
    coord_t vx, vy;
    logic   slot_free;
    logic   vertex_last;
    logic   beat_load;
    cell_t  beat;
    step_ctrl_t step_ctrl;

    logic signed [COORD_W:0] dx, dy, slope;
    logic signed [COORD_W:0] neg_dx, neg_dy;
    coord_t adx, ady, den, start_i, start_q, gap_init;
    logic   step_y_c;
    coord_t step_i, cross_coord;

    // range check on the incoming vertex
    always_comb
    begin
        vx = in_data.vertex_x[COORD_W-1:0];
        vy = in_data.vertex_y[COORD_W-1:0];
        in_range = !in_data.vertex_x[VERTEX_W-1] && !in_data.vertex_y[VERTEX_W-1]
                   && (in_data.vertex_x[GRID_W-1:0] < gw_reg)
                   && (in_data.vertex_y[GRID_W-1:0] < gh_reg)
                   && ({3'b000, in_data.vertex_x} < DIM_LIMIT)
                   && ({3'b000, in_data.vertex_y} < DIM_LIMIT);
    end

    // segment setup: pick the stepping axis and start from the lower endpoint
    always_comb
    begin
        dx     = $signed({1'b0, cur_x_reg}) - $signed({1'b0, old_x_reg});
        dy     = $signed({1'b0, cur_y_reg}) - $signed({1'b0, old_y_reg});
        neg_dx = -dx;
        neg_dy = -dy;
        adx    = dx[COORD_W] ? neg_dx[COORD_W-1:0] : dx[COORD_W-1:0];
        ady    = dy[COORD_W] ? neg_dy[COORD_W-1:0] : dy[COORD_W-1:0];
        step_y_c = (dx == '0) || (ady > adx);
        if (step_y_c)
        begin
            den     = ady;
            slope   = dy[COORD_W] ? neg_dx : dx;
            start_i = dy[COORD_W] ? cur_y_reg : old_y_reg;
            start_q = dy[COORD_W] ? cur_x_reg : old_x_reg;
        end
        else
        begin
            den     = adx;
            slope   = dx[COORD_W] ? neg_dy : dy;
            start_i = dx[COORD_W] ? cur_x_reg : old_x_reg;
            start_q = dx[COORD_W] ? cur_y_reg : old_y_reg;
        end
        gap_init = (had_reg && (den != '0)) ? den - 1'b1 : '0;
    end

    assign slot_free   = !out_valid_reg || !out_stall;
    assign vertex_last = oor_reg || (gap_cnt_reg == '0);

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = in_range ? ST_SETUP : ST_VERTEX;
            end
            ST_SETUP:
                state_next = ST_VERTEX;
            ST_VERTEX:
            begin
                if (slot_free)
                    state_next = vertex_last ? ST_IDLE : ST_GAP;
            end
            ST_GAP:
            begin
                if (slot_free && (gap_cnt_reg == coord_t'(1)))
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs and beat assembly
    always_comb
    begin
        in_stall          = (state_reg != ST_IDLE);
        accept            = in_valid && (state_reg == ST_IDLE);
        step_ctrl.load    = (state_reg == ST_SETUP);
        step_ctrl.advance = (state_reg == ST_GAP) && slot_free;
        beat_load         = slot_free && ((state_reg == ST_VERTEX) || (state_reg == ST_GAP));

        beat.box_min_x    = CELL_W'(min_x_reg);
        beat.box_min_y    = CELL_W'(min_y_reg);
        beat.box_max_x    = CELL_W'(max_x_reg);
        beat.box_max_y    = CELL_W'(max_y_reg);
        beat.box_valid    = have_point_reg;
        beat.out_of_range = 1'b0;
        beat.cell_x       = '0;
        beat.cell_y       = '0;
        beat.last_of_run  = 1'b0;
        if (state_reg == ST_GAP)
        begin
            beat.cell_x      = CELL_W'(step_y_reg ? cross_coord : step_i);
            beat.cell_y      = CELL_W'(step_y_reg ? step_i : cross_coord);
            beat.last_of_run = (gap_cnt_reg == coord_t'(1));
        end
        else
        begin
            beat.out_of_range = oor_reg;
            beat.last_of_run  = vertex_last;
            if (!oor_reg)
            begin
                beat.cell_x = CELL_W'(cur_x_reg);
                beat.cell_y = CELL_W'(cur_y_reg);
            end
        end
    end

    pler_stepper #(
        .COORD_W (COORD_W)
    ) u_stepper (
        .clk         (clk),
        .ctrl        (step_ctrl),
        .load_den    (den),
        .load_slope  (slope),
        .load_q      (start_q),
        .load_i      (start_i),
        .step_i      (step_i),
        .cross_coord (cross_coord)
    );

    // state and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            gw_reg         <= GRID_RESET;
            gh_reg         <= GRID_RESET;
            have_point_reg <= 1'b0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            min_x_reg      <= '0;
            min_y_reg      <= '0;
            max_x_reg      <= '0;
            max_y_reg      <= '0;
            oor_reg        <= 1'b0;
            had_reg        <= 1'b0;
            step_y_reg     <= 1'b0;
            gap_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GRID_WIDTH:  gw_reg <= cfg_data;
                    REG_GRID_HEIGHT: gh_reg <= cfg_data;
                    default:         ;
                endcase
            end

            if (accept)
            begin
                oor_reg <= !in_range;
                if (in_range)
                begin
                    had_reg        <= have_point_reg;
                    have_point_reg <= 1'b1;
                    prev_x_reg     <= vx;
                    prev_y_reg     <= vy;
                    if (!have_point_reg || vx < min_x_reg) min_x_reg <= vx;
                    if (!have_point_reg || vy < min_y_reg) min_y_reg <= vy;
                    if (!have_point_reg || vx > max_x_reg) max_x_reg <= vx;
                    if (!have_point_reg || vy > max_y_reg) max_y_reg <= vy;
                end
            end

            if (step_ctrl.load)
            begin
                step_y_reg  <= step_y_c;
                gap_cnt_reg <= gap_init;
            end
            else if (step_ctrl.advance)
                gap_cnt_reg <= gap_cnt_reg - 1'b1;

            if (beat_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // vertex working copies and output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_x_reg <= vx;
            cur_y_reg <= vy;
            old_x_reg <= prev_x_reg;
            old_y_reg <= prev_y_reg;
        end
        if (beat_load)
            out_data_reg <= beat;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    // a flagged beat is a lone, empty beat
    a_oor_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.out_of_range |->
            out_data.last_of_run && (out_data.cell_x == '0) && (out_data.cell_y == '0))
        else $error("out-of-range beat not single or not empty");

    // an accepted in-range vertex opens the box
    a_box_open: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_range |=> have_point_reg)
        else $error("box not valid after in-range vertex");

    // gap state never runs with an empty count
    a_gap_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_GAP |-> gap_cnt_reg != '0)
        else $error("gap state with zero cells left");

    // every marked cell lies inside the running box
    a_cell_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.out_of_range |->
            out_data.box_valid
            && (out_data.cell_x >= out_data.box_min_x) && (out_data.cell_x <= out_data.box_max_x)
            && (out_data.cell_y >= out_data.box_min_y) && (out_data.cell_y <= out_data.box_max_y))
        else $error("marked cell outside bounding box");

endmodule

// ===== rtl/pler_stepper.sv =====
// pler_stepper: incremental rational stepper for one segment.
// Keeps floor quotient and remainder of the cross coordinate and moves them
// one cell per advance with one add and a single fix-up by den; rounds half to even.
// Depends on pler_pkg.
`timescale 1ns / 1ps

module pler_stepper #(
    parameter int COORD_W = 6
) (
    input  logic                      clk,
    input  pler_pkg::step_ctrl_t      ctrl,
    input  logic [COORD_W-1:0]        load_den,
    input  logic signed [COORD_W:0]   load_slope,
    input  logic [COORD_W-1:0]        load_q,
    input  logic [COORD_W-1:0]        load_i,
    output logic [COORD_W-1:0]        step_i,
    output logic [COORD_W-1:0]        cross_coord
);

    logic [COORD_W-1:0]        den_reg;
    logic signed [COORD_W:0]   slope_reg;
    logic [COORD_W-1:0]        q_reg;
    logic [COORD_W-1:0]        r_reg;
    logic [COORD_W-1:0]        i_reg;

    logic [COORD_W-1:0]        q_next;
    logic [COORD_W-1:0]        r_next;
    logic [COORD_W-1:0]        i_next;
    logic signed [COORD_W+1:0] sum;
    logic signed [COORD_W+1:0] den_ext;
    logic signed [COORD_W+1:0] sum_up;
    logic signed [COORD_W+1:0] sum_down;
    logic [COORD_W:0]          twice_r;
    logic [COORD_W:0]          den_cmp;
    logic                      round_up;

    // remainder update: slope magnitude never exceeds den, so one fix-up is enough
    always_comb
    begin
        den_ext  = $signed({2'b00, den_reg});
        sum      = $signed({2'b00, r_reg}) + $signed({slope_reg[COORD_W], slope_reg});
        sum_up   = sum + den_ext;
        sum_down = sum - den_ext;
        if (sum < 0)
        begin
            r_next = sum_up[COORD_W-1:0];
            q_next = q_reg - 1'b1;
        end
        else if (sum >= den_ext)
        begin
            r_next = sum_down[COORD_W-1:0];
            q_next = q_reg + 1'b1;
        end
        else
        begin
            r_next = sum[COORD_W-1:0];
            q_next = q_reg;
        end
        i_next = i_reg + 1'b1;
    end

    // round to nearest, exact half to even
    always_comb
    begin
        twice_r     = {r_next, 1'b0};
        den_cmp     = {1'b0, den_reg};
        round_up    = (twice_r > den_cmp) || ((twice_r == den_cmp) && q_next[0]);
        cross_coord = q_next + COORD_W'(round_up);
        step_i      = i_next;
    end

    // segment registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            den_reg   <= load_den;
            slope_reg <= load_slope;
            q_reg     <= load_q;
            r_reg     <= '0;
            i_reg     <= load_i;
        end
        else if (ctrl.advance)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
            i_reg <= i_next;
        end
    end

endmodule
